[rtl/mecanum_wheel_odometry_assert.svh]
// Assertion macros for the mecanum odometry block.
// Included by the top level; uses its clock and reset names.
`ifndef MECANUM_WHEEL_ODOMETRY_ASSERT_SVH
`define MECANUM_WHEEL_ODOMETRY_ASSERT_SVH
`ifndef SYNTHESIS
`define MWO_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mwo check failed");
`define MWO_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mwo check failed");
`else
`define MWO_ASSERT_IMP(lbl, ante, cons)
`define MWO_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/mwo_pkg.sv]
// Shared types, constants and helper functions for mecanum odometry.
// No dependencies.
`default_nettype none
package mwo_pkg;
   typedef logic signed [31:0] sword_type;
   typedef logic [31:0]        uword_type;

   localparam int PROD_W = 68;
   localparam int MA_W   = 35;
   localparam int MB_W   = 33;
   localparam int NUM_W  = 62;
   localparam int DEN_W  = 41;
   localparam int CNT_W  = 6;

   localparam logic [31:0] MPT_RESET = 32'd2698608;
   localparam logic [31:0] HG_RESET  = 32'd488260702;
   localparam logic [19:0] MIN_RESET = 20'd1;

   localparam logic [1:0] CSR_MPT = 2'd0;
   localparam logic [1:0] CSR_HG  = 2'd1;
   localparam logic [1:0] CSR_MIN = 2'd2;

   localparam logic signed [33:0] CORDIC_K     = 34'sd652032874;
   localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
   localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;

   function automatic logic [31:0] atan_f(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051D;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2E;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2F9;
         5'd15: r = 32'h0000517C;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A2F;
         5'd19: r = 32'h00000517;
         5'd20: r = 32'h0000028B;
         5'd21: r = 32'h00000145;
         5'd22: r = 32'h000000A2;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000028;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000002;
         5'd29: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   // clamp a wide signed value into signed 32 bits
   function automatic logic signed [31:0] sat32_f(input logic signed [PROD_W-1:0] v);
      logic signed [31:0] r;
      if ((v[PROD_W-1:31] == '0) || (v[PROD_W-1:31] == '1)) r = v[31:0];
      else if (v[PROD_W-1]) r = 32'sh80000000;
      else r = 32'sh7FFFFFFF;
      return r;
   endfunction
endpackage
`default_nettype wire

[rtl/mwo_if.sv]
// Valid/ready channel interfaces for the odometry request and response.
// Depends on mwo_pkg.
`default_nettype none
interface mwo_req_if;
   import mwo_pkg::*;
   logic      valid;
   logic      ready;
   sword_type count_front_left;
   sword_type count_front_right;
   sword_type count_rear_left;
   sword_type count_rear_right;
   uword_type stamp_us;
   modport source(output valid, count_front_left, count_front_right, count_rear_left,
                  count_rear_right, stamp_us, input ready);
   modport sink(input valid, count_front_left, count_front_right, count_rear_left,
                count_rear_right, stamp_us, output ready);
endinterface

interface mwo_rsp_if;
   import mwo_pkg::*;
   logic      valid;
   logic      ready;
   sword_type pos_x;
   sword_type pos_y;
   uword_type heading;
   sword_type body_vel_x;
   sword_type body_vel_y;
   sword_type turn_rate;
   modport source(output valid, pos_x, pos_y, heading, body_vel_x, body_vel_y, turn_rate,
                  input ready);
   modport sink(input valid, pos_x, pos_y, heading, body_vel_x, body_vel_y, turn_rate,
                output ready);
endinterface
`default_nettype wire

[rtl/mecanum_wheel_odometry.sv]
// Mecanum wheel dead-reckoning odometry, top level.
// Depends on mwo_pkg, mwo_if and mecanum_wheel_odometry_assert.svh.
`default_nettype none
`include "mecanum_wheel_odometry_assert.svh"
// From acceptance to a result, an integrating transaction makes fifteen passes through
// one shared 35x33 multiplier, CORDIC_STEPS iterations of the sine/cosine unit, and
// three 62-step restoring divisions for the velocities, which dominate. A baseline or
// short-interval transaction finishes in the accept cycle with no result. The request
// side takes a new transaction as soon as the sequencer is idle, even while a result
// still waits.
module mecanum_wheel_odometry #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mwo_req_if.sink    req_ch,
   mwo_rsp_if.source  rsp_ch,
   input  wire logic  csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   import mwo_pkg::*;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_SUM   = 5'd1;
   localparam logic [4:0] S_M1    = 5'd2;
   localparam logic [4:0] S_M2    = 5'd3;
   localparam logic [4:0] S_M3    = 5'd4;
   localparam logic [4:0] S_M4    = 5'd5;
   localparam logic [4:0] S_M5    = 5'd6;
   localparam logic [4:0] S_M6    = 5'd7;
   localparam logic [4:0] S_M7    = 5'd8;
   localparam logic [4:0] S_M8    = 5'd9;
   localparam logic [4:0] S_M9    = 5'd10;
   localparam logic [4:0] S_M10   = 5'd11;
   localparam logic [4:0] S_M11   = 5'd12;
   localparam logic [4:0] S_M12   = 5'd13;
   localparam logic [4:0] S_M13   = 5'd14;
   localparam logic [4:0] S_CINIT = 5'd15;
   localparam logic [4:0] S_CITER = 5'd16;
   localparam logic [4:0] S_CEND  = 5'd17;
   localparam logic [4:0] S_W1    = 5'd18;
   localparam logic [4:0] S_W2    = 5'd19;
   localparam logic [4:0] S_W3    = 5'd20;
   localparam logic [4:0] S_W4    = 5'd21;
   localparam logic [4:0] S_W5    = 5'd22;
   localparam logic [4:0] S_DSET  = 5'd23;
   localparam logic [4:0] S_DITER = 5'd24;
   localparam logic [4:0] S_DEND  = 5'd25;
   localparam logic [4:0] S_DONE  = 5'd26;

   localparam logic [1:0] DSEL_X = 2'd0;
   localparam logic [1:0] DSEL_Y = 2'd1;
   localparam logic [1:0] DSEL_R = 2'd2;

   logic [4:0] state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0] mpt_ff, mpt_in, hg_ff, hg_in;
   logic [19:0] min_ff, min_in;
   logic [31:0] last_cnt_ff [4];
   logic [31:0] last_cnt_in [4];
   logic [31:0] last_stamp_ff, last_stamp_in;
   logic base_ok_ff, base_ok_in;
   logic signed [31:0] posx_ff, posx_in, posy_ff, posy_in;
   logic [31:0] head_ff, head_in;
   logic signed [31:0] d_ff [4];
   logic signed [31:0] d_in [4];
   logic [30:0] dt_ff, dt_in;
   logic signed [33:0] sx_ff, sx_in, sy_ff, sy_in, sr_ff, sr_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in, acc_ff, acc_in;
   logic signed [31:0] dxb_ff, dxb_in, dyb_ff, dyb_in, rc_ff, rc_in;
   logic signed [47:0] dh_ff, dh_in;
   logic signed [NUM_W-1:0] numx_ff, numx_in, numy_ff, numy_in, numr_ff, numr_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic flip_ff, flip_in;
   logic signed [32:0] c_ff, c_in, s_ff, s_in;
   logic signed [37:0] wx_ff, wx_in;
   logic [1:0] dsel_ff, dsel_in;
   logic [NUM_W-1:0] dq_ff, dq_in;
   logic [DEN_W-1:0] drem_ff, drem_in, dden_ff, dden_in;
   logic dneg_ff, dneg_in;
   logic signed [31:0] vx_ff, vx_in, vy_ff, vy_in, tr_ff, tr_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rx_ff, rx_in, ry_ff, ry_in, rvx_ff, rvx_in, rvy_ff, rvy_in;
   logic signed [31:0] rtr_ff, rtr_in;
   logic [31:0] rh_ff, rh_in;

   logic signed [MA_W-1:0] mul_a;
   logic signed [MB_W-1:0] mul_b;
   logic signed [PROD_W-1:0] acc_sum, acc_dif;
   logic req_fire;
   logic [31:0] dt_raw;
   logic short_dt;
   logic signed [33:0] zf, xs, ys, at;
   logic signed [NUM_W-1:0] dnum;
   logic [DEN_W:0] rsh, rdif;
   logic qbig;
   logic signed [31:0] qres;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign prod_in = mul_a * mul_b;
   assign acc_sum = acc_ff + prod_ff;
   assign acc_dif = acc_ff - prod_ff;
   assign dt_raw = req_ch.stamp_us - last_stamp_ff;
   assign short_dt = $signed(dt_raw) <= $signed({12'b0, min_ff});

   assign xs = cx_ff >>> cnt_ff[4:0];
   assign ys = cy_ff >>> cnt_ff[4:0];
   assign at = $signed({2'b0, atan_f(cnt_ff[4:0])});

   assign rsh  = {drem_ff, dq_ff[NUM_W-1]};
   assign rdif = rsh - {1'b0, dden_ff};
   assign qbig = |dq_ff[NUM_W-1:32];

   always_comb begin
      case (dsel_ff)
         DSEL_X:  dnum = numx_ff;
         DSEL_Y:  dnum = numy_ff;
         default: dnum = numr_ff;
      endcase
      // truncating quotient with signed 32-bit saturation
      if (dneg_ff) begin
         if (qbig || (dq_ff[31] && (|dq_ff[30:0]))) qres = 32'sh80000000;
         else qres = -$signed(dq_ff[31:0]);
      end else begin
         if (qbig || dq_ff[31]) qres = 32'sh7FFFFFFF;
         else qres = $signed(dq_ff[31:0]);
      end
      zf = 34'($signed(head_ff));
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      mpt_in = mpt_ff;
      hg_in = hg_ff;
      min_in = min_ff;
      last_cnt_in = last_cnt_ff;
      last_stamp_in = last_stamp_ff;
      base_ok_in = base_ok_ff;
      posx_in = posx_ff;
      posy_in = posy_ff;
      head_in = head_ff;
      d_in = d_ff;
      dt_in = dt_ff;
      sx_in = sx_ff;
      sy_in = sy_ff;
      sr_in = sr_ff;
      acc_in = acc_ff;
      dxb_in = dxb_ff;
      dyb_in = dyb_ff;
      rc_in = rc_ff;
      dh_in = dh_ff;
      numx_in = numx_ff;
      numy_in = numy_ff;
      numr_in = numr_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      cz_in = cz_ff;
      flip_in = flip_ff;
      c_in = c_ff;
      s_in = s_ff;
      wx_in = wx_ff;
      dsel_in = dsel_ff;
      dq_in = dq_ff;
      drem_in = drem_ff;
      dden_in = dden_ff;
      dneg_in = dneg_ff;
      vx_in = vx_ff;
      vy_in = vy_ff;
      tr_in = tr_ff;
      rx_in = rx_ff;
      ry_in = ry_ff;
      rh_in = rh_ff;
      rvx_in = rvx_ff;
      rvy_in = rvy_ff;
      rtr_in = rtr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      mul_a = '0;
      mul_b = '0;

      if (csr_we) begin
         case (csr_index)
            CSR_MPT: mpt_in = csr_wdata;
            CSR_HG:  hg_in = csr_wdata;
            CSR_MIN: min_in = csr_wdata[19:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               d_in[0] = req_ch.count_front_left - last_cnt_ff[0];
               d_in[1] = req_ch.count_front_right - last_cnt_ff[1];
               d_in[2] = req_ch.count_rear_left - last_cnt_ff[2];
               d_in[3] = req_ch.count_rear_right - last_cnt_ff[3];
               dt_in = dt_raw[30:0];
               last_cnt_in[0] = req_ch.count_front_left;
               last_cnt_in[1] = req_ch.count_front_right;
               last_cnt_in[2] = req_ch.count_rear_left;
               last_cnt_in[3] = req_ch.count_rear_right;
               last_stamp_in = req_ch.stamp_us;
               base_ok_in = 1'b1;
               if (base_ok_ff && !short_dt) state_in = S_SUM;
            end
         end
         S_SUM: begin
            sx_in = 34'(d_ff[0]) + 34'(d_ff[1]) + 34'(d_ff[2]) + 34'(d_ff[3]);
            sy_in = -34'(d_ff[0]) + 34'(d_ff[1]) + 34'(d_ff[2]) - 34'(d_ff[3]);
            sr_in = -34'(d_ff[0]) + 34'(d_ff[1]) - 34'(d_ff[2]) + 34'(d_ff[3]);
            state_in = S_M1;
         end
         // ticks times meters_per_tick, split at bit 16 of the scale
         S_M1: begin
            mul_a = MA_W'(sx_ff);
            mul_b = {17'b0, mpt_ff[31:16]};
            state_in = S_M2;
         end
         S_M2: begin
            acc_in = prod_ff <<< 16;
            mul_a = MA_W'(sx_ff);
            mul_b = {17'b0, mpt_ff[15:0]};
            state_in = S_M3;
         end
         S_M3: begin
            dxb_in = sat32_f(acc_sum >>> 18);
            mul_a = MA_W'(sy_ff);
            mul_b = {17'b0, mpt_ff[31:16]};
            state_in = S_M4;
         end
         S_M4: begin
            acc_in = prod_ff <<< 16;
            mul_a = MA_W'(sy_ff);
            mul_b = {17'b0, mpt_ff[15:0]};
            state_in = S_M5;
         end
         S_M5: begin
            dyb_in = sat32_f(acc_sum >>> 18);
            mul_a = MA_W'(sr_ff);
            mul_b = {17'b0, mpt_ff[31:16]};
            state_in = S_M6;
         end
         S_M6: begin
            acc_in = prod_ff <<< 16;
            mul_a = MA_W'(sr_ff);
            mul_b = {17'b0, mpt_ff[15:0]};
            state_in = S_M7;
         end
         S_M7: begin
            rc_in = sat32_f(acc_sum >>> 16);
            state_in = S_M8;
         end
         S_M8: begin
            mul_a = MA_W'(rc_ff);
            mul_b = {1'b0, hg_ff};
            state_in = S_M9;
         end
         S_M9: begin
            dh_in = prod_ff[63:16];
            mul_a = MA_W'(dxb_ff);
            mul_b = 33'sd1000000;
            state_in = S_M10;
         end
         S_M10: begin
            numx_in = prod_ff[NUM_W-1:0];
            mul_a = MA_W'(dyb_ff);
            mul_b = 33'sd1000000;
            state_in = S_M11;
         end
         // heading delta times 15625, split at bit 24
         S_M11: begin
            numy_in = prod_ff[NUM_W-1:0];
            mul_a = MA_W'($signed(dh_ff[47:24]));
            mul_b = 33'sd15625;
            state_in = S_M12;
         end
         S_M12: begin
            acc_in = prod_ff <<< 24;
            mul_a = {11'b0, dh_ff[23:0]};
            mul_b = 33'sd15625;
            state_in = S_M13;
         end
         S_M13: begin
            numr_in = acc_sum[NUM_W-1:0];
            state_in = S_CINIT;
         end
         // fold heading into the half turn around zero
         S_CINIT: begin
            cx_in = CORDIC_K;
            cy_in = '0;
            cnt_in = '0;
            if (zf > QUARTER_TURN) begin
               cz_in = zf - HALF_TURN;
               flip_in = 1'b1;
            end else if (zf < -QUARTER_TURN) begin
               cz_in = zf + HALF_TURN;
               flip_in = 1'b1;
            end else begin
               cz_in = zf;
               flip_in = 1'b0;
            end
            state_in = S_CITER;
         end
         S_CITER: begin
            if (!cz_ff[33]) begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - at;
            end else begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + at;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) state_in = S_CEND;
         end
         S_CEND: begin
            c_in = flip_ff ? 33'(-cx_ff) : 33'(cx_ff);
            s_in = flip_ff ? 33'(-cy_ff) : 33'(cy_ff);
            state_in = S_W1;
         end
         S_W1: begin
            mul_a = MA_W'(dxb_ff);
            mul_b = c_ff;
            state_in = S_W2;
         end
         S_W2: begin
            acc_in = prod_ff;
            mul_a = MA_W'(dyb_ff);
            mul_b = s_ff;
            state_in = S_W3;
         end
         S_W3: begin
            wx_in = 38'(acc_dif >>> 30);
            mul_a = MA_W'(dxb_ff);
            mul_b = s_ff;
            state_in = S_W4;
         end
         S_W4: begin
            acc_in = prod_ff;
            mul_a = MA_W'(dyb_ff);
            mul_b = c_ff;
            state_in = S_W5;
         end
         S_W5: begin
            posx_in = sat32_f(PROD_W'(posx_ff) + PROD_W'(wx_ff));
            posy_in = sat32_f(PROD_W'(posy_ff) + (acc_sum >>> 30));
            head_in = head_ff + dh_ff[31:0];
            dsel_in = DSEL_X;
            state_in = S_DSET;
         end
         S_DSET: begin
            dneg_in = dnum[NUM_W-1];
            dq_in = dnum[NUM_W-1] ? NUM_W'(-dnum) : NUM_W'(dnum);
            dden_in = (dsel_ff == DSEL_R) ? {dt_ff, 10'b0} : {10'b0, dt_ff};
            drem_in = '0;
            cnt_in = '0;
            state_in = S_DITER;
         end
         S_DITER: begin
            drem_in = rdif[DEN_W] ? rsh[DEN_W-1:0] : rdif[DEN_W-1:0];
            dq_in = {dq_ff[NUM_W-2:0], !rdif[DEN_W]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) state_in = S_DEND;
         end
         S_DEND: begin
            case (dsel_ff)
               DSEL_X: begin
                  vx_in = qres;
                  dsel_in = DSEL_Y;
                  state_in = S_DSET;
               end
               DSEL_Y: begin
                  vy_in = qres;
                  dsel_in = DSEL_R;
                  state_in = S_DSET;
               end
               default: begin
                  tr_in = qres;
                  state_in = S_DONE;
               end
            endcase
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rx_in = posx_ff;
               ry_in = posy_ff;
               rh_in = head_ff;
               rvx_in = vx_ff;
               rvy_in = vy_ff;
               rtr_in = tr_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         mpt_ff <= MPT_RESET;
         hg_ff <= HG_RESET;
         min_ff <= MIN_RESET;
         last_cnt_ff <= '{default: '0};
         last_stamp_ff <= '0;
         base_ok_ff <= 1'b0;
         posx_ff <= '0;
         posy_ff <= '0;
         head_ff <= '0;
         rsp_valid_ff <= 1'b0;
         dsel_ff <= DSEL_X;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         mpt_ff <= mpt_in;
         hg_ff <= hg_in;
         min_ff <= min_in;
         last_cnt_ff <= last_cnt_in;
         last_stamp_ff <= last_stamp_in;
         base_ok_ff <= base_ok_in;
         posx_ff <= posx_in;
         posy_ff <= posy_in;
         head_ff <= head_in;
         rsp_valid_ff <= rsp_valid_in;
         dsel_ff <= dsel_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff <= d_in;
      dt_ff <= dt_in;
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      sr_ff <= sr_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      dxb_ff <= dxb_in;
      dyb_ff <= dyb_in;
      rc_ff <= rc_in;
      dh_ff <= dh_in;
      numx_ff <= numx_in;
      numy_ff <= numy_in;
      numr_ff <= numr_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      cz_ff <= cz_in;
      flip_ff <= flip_in;
      c_ff <= c_in;
      s_ff <= s_in;
      wx_ff <= wx_in;
      dq_ff <= dq_in;
      drem_ff <= drem_in;
      dden_ff <= dden_in;
      dneg_ff <= dneg_in;
      vx_ff <= vx_in;
      vy_ff <= vy_in;
      tr_ff <= tr_in;
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      rh_ff <= rh_in;
      rvx_ff <= rvx_in;
      rvy_ff <= rvy_in;
      rtr_ff <= rtr_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.pos_x = rx_ff;
   assign rsp_ch.pos_y = ry_ff;
   assign rsp_ch.heading = rh_ff;
   assign rsp_ch.body_vel_x = rvx_ff;
   assign rsp_ch.body_vel_y = rvy_ff;
   assign rsp_ch.turn_rate = rtr_ff;

   `MWO_ASSERT_NXT(a_baseline_only, req_fire && !base_ok_ff, (state_ff == S_IDLE) && base_ok_ff)
   `MWO_ASSERT_NXT(a_done_loads, (state_ff == S_DONE) && !rsp_valid_ff, rsp_valid_ff)
   `MWO_ASSERT_IMP(a_div_count, state_ff == S_DITER, cnt_ff <= CNT_W'(NUM_W - 1))
endmodule
`default_nettype wire

[dv/tb_mecanum_wheel_odometry.sv]
// Self-checking testbench for mecanum_wheel_odometry: drives encoder samples,
// predicts pose/velocity transactions in a scoreboard class, checks every response.
// Depends on mwo_pkg, mwo_if and the RTL top level.
`timescale 1ns / 100ps
`default_nettype none

module tb_mecanum_wheel_odometry;
   import mwo_pkg::*;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int         SETTLE_CYCLES = 260;
   localparam int         WATCHDOG_LIMIT = 6000;

   typedef struct {
      sword_type fl, fr, rl, rr;
      uword_type stamp;
   } sample_type;

   typedef struct {
      sword_type pos_x, pos_y;
      uword_type heading;
      sword_type vel_x, vel_y, turn_rate;
   } pose_type;

   class odometry_scoreboard;
      logic [31:0] mpt, gain;
      logic [19:0] min_dt;
      logic [31:0] base_cnt[4];
      logic [31:0] base_stamp;
      bit          have_base;
      logic signed [31:0] px, py;
      logic [31:0] hdg;
      pose_type    pending_q[$];
      int          errors, results, integrations, baselines;
      longint      atan_lut[30];

      function new();
         atan_lut = '{64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
                      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
                      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
                      64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
                      64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
                      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001};
         mpt = MPT_RESET; gain = HG_RESET; min_dt = MIN_RESET;
         foreach (base_cnt[k]) base_cnt[k] = '0;
         base_stamp = '0; have_base = 0; px = 0; py = 0; hdg = 0;
         errors = 0; results = 0; integrations = 0; baselines = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] data);
         case (idx)
            CSR_MPT: mpt = data;
            CSR_HG:  gain = data;
            CSR_MIN: min_dt = data[19:0];
            default: ;
         endcase
      endfunction

      static function longint sext(logic [31:0] u);
         return longint'($signed(u));
      endfunction

      static function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // ticks times Q0.32 scale, split so the product stays in 64 bits
      function longint ticks_to_meters(longint t, int unsigned extra);
         longint hi, lo;
         hi = longint'(mpt >> 16);
         lo = longint'(mpt & 32'hFFFF);
         return (t * hi + ((t * lo) >>> 16)) >>> extra;
      endfunction

      function void sin_cos(logic [31:0] ang, output longint c, output longint s);
         longint z, x, y, nx;
         bit     flip;
         z = sext(ang); x = 652032874; y = 0; flip = 0;
         if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648; flip = 1;
         end else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648; flip = 1;
         end
         for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i); y = y + (x >>> i); z -= atan_lut[i];
            end else begin
               nx = x + (y >>> i); y = y - (x >>> i); z += atan_lut[i];
            end
            x = nx;
         end
         c = flip ? -x : x;
         s = flip ? -y : y;
      endfunction

      function void rebase(sample_type smp);
         base_cnt[0] = smp.fl; base_cnt[1] = smp.fr;
         base_cnt[2] = smp.rl; base_cnt[3] = smp.rr;
         base_stamp = smp.stamp;
      endfunction

      function void note_sample(sample_type smp);
         longint d[4], dt, sx, sy, sr, dxb, dyb, rc, dh, c, s;
         logic [31:0] cur[4];
         pose_type p;
         if (!have_base) begin
            have_base = 1; rebase(smp); baselines++;
            return;
         end
         dt = sext(smp.stamp - base_stamp);
         if (dt <= longint'(min_dt)) begin
            rebase(smp); baselines++;
            return;
         end
         cur[0] = smp.fl; cur[1] = smp.fr; cur[2] = smp.rl; cur[3] = smp.rr;
         for (int k = 0; k < 4; k++) d[k] = sext(cur[k] - base_cnt[k]);
         sx = d[0] + d[1] + d[2] + d[3];
         sy = -d[0] + d[1] + d[2] - d[3];
         sr = -d[0] + d[1] - d[2] + d[3];
         dxb = clamp32(ticks_to_meters(sx, 2));
         dyb = clamp32(ticks_to_meters(sy, 2));
         rc = clamp32(ticks_to_meters(sr, 0));
         dh = (rc * longint'(gain)) >>> 16;
         sin_cos(hdg, c, s);
         px = clamp32(longint'(px) + ((dxb * c - dyb * s) >>> 30));
         py = clamp32(longint'(py) + ((dxb * s + dyb * c) >>> 30));
         hdg = hdg + dh[31:0];
         p.pos_x = px; p.pos_y = py; p.heading = hdg;
         p.vel_x = clamp32(dxb * 1000000 / dt);
         p.vel_y = clamp32(dyb * 1000000 / dt);
         p.turn_rate = clamp32(dh * 15625 / (dt * 1024));
         pending_q.push_back(p);
         rebase(smp);
         integrations++;
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
      endtask

      task check_result(pose_type got);
         pose_type want;
         results++;
         if (pending_q.size() == 0) begin
            report_mismatch("unexpected transaction pos_x", got.pos_x, 0);
            return;
         end
         want = pending_q.pop_front();
         if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
         if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
         if (got.heading !== want.heading) report_mismatch("heading", got.heading, want.heading);
         if (got.vel_x !== want.vel_x) report_mismatch("body_vel_x", got.vel_x, want.vel_x);
         if (got.vel_y !== want.vel_y) report_mismatch("body_vel_y", got.vel_y, want.vel_y);
         if (got.turn_rate !== want.turn_rate)
            report_mismatch("turn_rate", got.turn_rate, want.turn_rate);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   mwo_req_if req_ch();
   mwo_rsp_if rsp_ch();

   mecanum_wheel_odometry u_top (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   odometry_scoreboard odo_sb = new();
   sample_type last_sent;
   int idle_cycles = 0;
   int stall_left = 0;
   bit no_idle = 0;
   int samples_sent = 0;

   initial begin
      req_ch.valid = 0;
      req_ch.count_front_left = '0; req_ch.count_front_right = '0;
      req_ch.count_rear_left = '0; req_ch.count_rear_right = '0;
      req_ch.stamp_us = '0;
      rsp_ch.ready = 0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 95) return $urandom_range(1, 4);
      return $urandom_range(20, 80);
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 0;
         stall_left <= stall_left - 1;
      end else begin
         int g;
         g = pick_gap();
         rsp_ch.ready <= (g == 0);
         if (g > 1) stall_left <= g - 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         pose_type got;
         got.pos_x = rsp_ch.pos_x; got.pos_y = rsp_ch.pos_y; got.heading = rsp_ch.heading;
         got.vel_x = rsp_ch.body_vel_x; got.vel_y = rsp_ch.body_vel_y;
         got.turn_rate = rsp_ch.turn_rate;
         odo_sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d transactions pending", odo_sb.pending_q.size());
         $display("FAIL");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   task automatic send_sample(sample_type smp);
      int g;
      g = pick_gap();
      @(negedge clock);
      if (g > 0) begin
         req_ch.valid = 0;
         repeat (g) @(negedge clock);
      end
      req_ch.count_front_left = smp.fl; req_ch.count_front_right = smp.fr;
      req_ch.count_rear_left = smp.rl; req_ch.count_rear_right = smp.rr;
      req_ch.stamp_us = smp.stamp;
      req_ch.valid = 1;
      do @(posedge clock); while (!req_ch.ready);
      odo_sb.note_sample(smp);
      last_sent = smp;
      samples_sent++;
   endtask

   // lower valid, let every expected transaction drain, then let the pipe settle
   task automatic drain();
      @(negedge clock);
      req_ch.valid = 0;
      while (odo_sb.pending_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_we = 1; csr_index = idx; csr_wdata = data;
      odo_sb.write_reg(idx, data);
      @(negedge clock);
      csr_we = 0;
   endtask

   function automatic sample_type make_sample(sword_type fl, sword_type fr, sword_type rl,
                                              sword_type rr, uword_type st);
      sample_type smp;
      smp.fl = fl; smp.fr = fr; smp.rl = rl; smp.rr = rr; smp.stamp = st;
      return smp;
   endfunction

   task automatic random_sample();
      sample_type smp;
      int kind, span;
      logic [31:0] step;
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
         span = ($urandom_range(0, 9) == 0) ? 32'h7FFFFFFF : 2000;
         smp.fl = last_sent.fl + $signed($urandom_range(0, 2 * span) - span);
         smp.fr = last_sent.fr + $signed($urandom_range(0, 2 * span) - span);
         smp.rl = last_sent.rl + $signed($urandom_range(0, 2 * span) - span);
         smp.rr = last_sent.rr + $signed($urandom_range(0, 2 * span) - span);
         step = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 32'h7FFFFFFF - 32'd1000001)
                                             : $urandom_range(1, 5000);
         smp.stamp = last_sent.stamp + odo_sb.min_dt + step;
      end else if (kind < 95) begin
         smp = last_sent;
         smp.fl = smp.fl + $signed($urandom_range(0, 200) - 100);
         smp.stamp = last_sent.stamp + odo_sb.min_dt - $urandom_range(0, 50);
      end else begin
         smp = make_sample($urandom, $urandom, $urandom, $urandom, $urandom);
      end
      send_sample(smp);
   endtask

   logic [31:0] cfg_mpt[6] = '{32'd2698608, 32'd0, 32'hFFFFFFFF, 32'd100000, 32'd5000000,
                               32'd2698608};
   logic [31:0] cfg_hg[6]  = '{32'd488260702, 32'hFFFFFFFF, 32'd0, 32'd7, 32'd1000000000,
                               32'd488260702};
   logic [31:0] cfg_min[6] = '{32'd1, 32'd0, 32'd1000000, 32'd20, 32'd3, 32'd1};

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: baseline, short/backward/equal intervals, extremes, huge motion
      send_sample(make_sample(32'sh7FFFFFFF, -32'sh80000000, 0, -1, 32'hFFFFFFF0));
      send_sample(make_sample(32'sh7FFFFFFF, -32'sh80000000, 0, -1, 32'hFFFFFFF1));
      send_sample(make_sample(100, 100, 100, 100, 32'hFFFFFFF0));
      send_sample(make_sample(200, 200, 200, 200, 32'h00000010));
      send_sample(make_sample(100, 300, 100, 300, 32'h00000400));
      send_sample(make_sample(-500, 900, 900, -500, 32'h00000800));
      send_sample(make_sample(32'sh7FFFFF00, -32'sh7FFFFF00, 32'sh7FFFFF00, -32'sh7FFFFF00,
                              32'h00000900));
      send_sample(make_sample(-32'sh80000000, 32'sh7FFFFFFF, -32'sh80000000, 32'sh7FFFFFFF,
                              32'h00000902));
      send_sample(make_sample(0, 0, 0, 0, 32'h80000901));
      send_sample(make_sample(0, 0, 0, 0, 32'h80000901));
      send_sample(make_sample(-1, -1, -1, -1, 32'hFFFFFFFF));
      send_sample(make_sample(32'sh55555555, 32'shAAAAAAAA, 32'sh0F0F0F0F, 32'shF0F0F0F0,
                              32'h0000FFFF));
      for (int i = 0; i < 8; i++)
         send_sample(make_sample(last_sent.fl - 40, last_sent.fr + 40, last_sent.rl - 40,
                                 last_sent.rr + 40, last_sent.stamp + 1000));

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         write_csr(CSR_MPT, cfg_mpt[ph]);
         write_csr(CSR_HG, cfg_hg[ph]);
         write_csr(CSR_MIN, cfg_min[ph]);
         write_csr(CSR_UNUSED, $urandom);
         no_idle = (ph == 3);
         for (int n = 0; n < 245; n++) begin
            random_sample();
            if (n == 120) drain();
         end
      end

      drain();
      $display("%0d samples sent, %0d integrated, %0d baselines, %0d responses checked",
               samples_sent, odo_sb.integrations, odo_sb.baselines, odo_sb.results);
      $display("six register settings incl. zero and full-scale gains and interval limits");
      if (odo_sb.errors == 0 && odo_sb.pending_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

`default_nettype wire
